// ===== hw/rtl/pgw_pkg.sv =====
// Shared types and constants for the stage-1 page table walker.
package pgw_pkg;

  localparam int TABLE_ENTRIES = 512;
  localparam int ENTRY_W       = 9;
  localparam int SLOT_W        = 8;
  localparam int CFG_DATA_W    = 36;
  localparam int CFG_INDEX_W   = 3;

  localparam logic [47:0] ADDR_BITS = 48'hFFFF_FFFF_F000;

  typedef enum logic {
    OP_WRITE     = 1'b0,
    OP_TRANSLATE = 1'b1
  } pgw_op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROOT_TABLE      = 3'd0,
    REG_TABLE_BASE_PAGE = 3'd1,
    REG_CONTEXT_KERNEL  = 3'd2,
    REG_DEVICE_ATTR     = 3'd3,
    REG_NONCACHED_ATTR  = 3'd4
  } pgw_reg_t;

  localparam logic [1:0] CACHE_WB     = 2'd0;
  localparam logic [1:0] CACHE_NC     = 2'd1;
  localparam logic [1:0] CACHE_DEVICE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } pgw_state_t;

  typedef struct packed {
    logic        op;
    logic [63:0] virt_addr;
    logic [12:0] word_index;
    logic [63:0] word_data;
  } pgw_req_t;

  typedef struct packed {
    logic        hit;
    logic        bad_table;
    logic [47:0] phys_addr;
    logic        can_write;
    logic        can_exec;
    logic        is_user;
    logic [1:0]  cache_mode;
    logic [1:0]  size_level;
  } pgw_rsp_t;

  typedef struct packed {
    logic [3:0]  root_table;
    logic [35:0] table_base_page;
    logic        context_is_kernel;
    logic [2:0]  device_attr_index;
    logic [2:0]  noncached_attr_index;
  } pgw_cfg_t;

  // Table index bits of the VA for a given level (3 is the root).
  function automatic logic [ENTRY_W-1:0] va_index(input logic [47:0] va,
                                                  input logic [1:0] lvl);
    logic [ENTRY_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[20:12];
      2'd1:    idx = va[29:21];
      2'd2:    idx = va[38:30];
      default: idx = va[47:39];
    endcase
    return idx;
  endfunction

  // Page offset mask of a leaf at a given level.
  function automatic logic [47:0] offset_mask(input logic [1:0] lvl);
    logic [47:0] m;
    case (lvl)
      2'd0:    m = 48'h0000_0000_0FFF;
      2'd1:    m = 48'h0000_001F_FFFF;
      2'd2:    m = 48'h0000_3FFF_FFFF;
      default: m = 48'h007F_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/pgw_table_mem.sv =====
// Descriptor store: single-port-write, registered-read memory with a clear sweep after reset.
module pgw_table_mem import pgw_pkg::*; #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data,
  output logic          clearing
);

  logic [63:0]   mem [DEPTH];
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/pgw_walker.sv =====
// Walk sequencer: descriptor writes, level-by-level table reads and leaf decode.
module pgw_walker import pgw_pkg::*; #(
  parameter int NUM_TABLES = 16,
  parameter int AW         = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  pgw_cfg_t      cfg,
  input  logic          start,
  input  pgw_req_t      request,
  input  logic          clearing,
  output logic          busy,
  output logic          done,
  output pgw_rsp_t      result,
  output logic          mem_wr_en,
  output logic [AW-1:0] mem_wr_addr,
  output logic [63:0]   mem_wr_data,
  output logic          mem_rd_en,
  output logic [AW-1:0] mem_rd_addr,
  input  logic [63:0]   mem_rd_data
);

  localparam logic [31:0] STORE_WORDS = 32'(NUM_TABLES * TABLE_ENTRIES);
  localparam logic [31:0] NUM_SLOTS   = 32'(NUM_TABLES);

  pgw_state_t  state, state_next;
  logic [1:0]  lvl, lvl_next;
  logic [47:0] va;
  logic        done_next;
  pgw_rsp_t    result_next;

  logic        accept;
  logic [63:0] e;
  logic        leaf;
  logic [36:0] slot_diff;
  logic        slot_ok;
  logic [2:0]  attr;
  logic [47:0] mask;
  logic [1:0]  lvl_down;

  assign accept = start && !clearing && (state == ST_IDLE);
  assign busy   = clearing || (state != ST_IDLE);
  assign e      = mem_rd_data;
  assign leaf   = (lvl == 2'd0) || !e[1];
  assign attr   = e[4:2];
  assign mask   = offset_mask(lvl);
  assign lvl_down = lvl - 2'd1;

  // Next-table page relative to the store base; must land on a slot we hold.
  assign slot_diff = {1'b0, e[47:12]} - {1'b0, cfg.table_base_page};
  assign slot_ok   = !slot_diff[36] && ({28'd0, slot_diff[35:0]} < {32'd0, NUM_SLOTS});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    lvl    <= lvl_next;
    result <= result_next;
    if (accept) begin
      va <= request.virt_addr[47:0];
    end
  end

  always_comb begin
    state_next  = state;
    lvl_next    = lvl;
    done_next   = 1'b0;
    result_next = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(request.word_index);
    mem_wr_data = request.word_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'({SLOT_W'(cfg.root_table), va_index(request.virt_addr[47:0], 2'd3)});

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (request.op == OP_WRITE) begin
            mem_wr_en = {19'd0, request.word_index} < STORE_WORDS;
            done_next = 1'b1;
          end else if (request.virt_addr[55] != cfg.context_is_kernel) begin
            done_next = 1'b1;
          end else if ({28'd0, cfg.root_table} >= NUM_SLOTS) begin
            done_next             = 1'b1;
            result_next.bad_table = 1'b1;
          end else begin
            mem_rd_en  = 1'b1;
            lvl_next   = 2'd3;
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!e[0]) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (leaf) begin
          done_next              = 1'b1;
          state_next             = ST_IDLE;
          result_next.hit        = 1'b1;
          result_next.phys_addr  = (e[47:0] & ADDR_BITS & ~mask) | (va & mask);
          result_next.can_write  = !e[7];
          result_next.can_exec   = e[6] ? !e[54] : !e[53];
          result_next.is_user    = e[6];
          result_next.size_level = lvl;
          if (attr == cfg.device_attr_index) begin
            result_next.cache_mode = CACHE_DEVICE;
          end else if (attr == cfg.noncached_attr_index) begin
            result_next.cache_mode = CACHE_NC;
          end else begin
            result_next.cache_mode = CACHE_WB;
          end
        end else if (!slot_ok) begin
          done_next             = 1'b1;
          state_next            = ST_IDLE;
          result_next.bad_table = 1'b1;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'({slot_diff[SLOT_W-1:0], va_index(va, lvl_down)});
          lvl_next    = lvl_down;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/stage1_page_table_walker.sv =====
// Top level of the stage-1 page table walker: configuration registers and block wiring.
//
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   request.op selects a descriptor write (word_index, word_data) or a
//   translation of request.virt_addr. Every transaction yields exactly one
//   result, shown on result for a single cycle with done high; the receiver
//   must take it then, it cannot stall the block.
//   Descriptor write: result in the cycle after acceptance, busy stays low, so
//   writes run one per cycle.
//   Translation: at acceptance the VA half is checked and the root read
//   issued, then each table level is read from the descriptor memory in turn
//   (at most four dependent reads of the store); busy is high during the walk.
//   Configuration: cfg_we writes cfg_data to register cfg_index. The user
//   must write only while no transaction is in flight; the block does not
//   enforce it. Reset: the configuration registers and walker state take
//   their reset values and the descriptor store is swept to zero, one entry
//   per cycle; busy stays high until the sweep ends. Configuration writes
//   are taken meanwhile.
module stage1_page_table_walker import pgw_pkg::*; #(
  parameter int NUM_TABLES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  pgw_req_t               request,
  output logic                   done,
  output pgw_rsp_t               result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = NUM_TABLES * TABLE_ENTRIES;
  localparam int AW    = $clog2(DEPTH);

  pgw_cfg_t      cfg;
  logic          clearing;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [63:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [63:0]   mem_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.root_table           <= '0;
      cfg.table_base_page      <= '0;
      cfg.context_is_kernel    <= 1'b0;
      cfg.device_attr_index    <= 3'd0;
      cfg.noncached_attr_index <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROOT_TABLE:      cfg.root_table           <= cfg_data[3:0];
        REG_TABLE_BASE_PAGE: cfg.table_base_page      <= cfg_data;
        REG_CONTEXT_KERNEL:  cfg.context_is_kernel    <= cfg_data[0];
        REG_DEVICE_ATTR:     cfg.device_attr_index    <= cfg_data[2:0];
        REG_NONCACHED_ATTR:  cfg.noncached_attr_index <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  pgw_walker #(
    .NUM_TABLES(NUM_TABLES),
    .AW        (AW)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .request    (request),
    .clearing   (clearing),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  pgw_table_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .clearing(clearing)
  );

endmodule

// ===== tb/tb_stage1_page_table_walker.sv =====
// Self-checking testbench for the stage-1 page table walker: directed table, then random walks.
`timescale 1ns / 100ps

module tb_stage1_page_table_walker;
  import pgw_pkg::*;

  localparam int NUM_TABLES    = 16;
  localparam int STALL_LIMIT   = 30000;
  localparam int SETS_PER_PASS = 4;
  localparam int ITEMS_PER_SET = 134;
  localparam logic [63:0] WALK_VA =
      (64'd1 << 39) | (64'd2 << 30) | (64'd3 << 21) | (64'd4 << 12) | 64'hABC;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } stim_kind_t;

  typedef struct {
    stim_kind_t kind;
    pgw_req_t   req;
    pgw_cfg_t   cfg;
    bit         has_exp;
    pgw_rsp_t   exp_rsp;
  } stim_row_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  pgw_req_t request;
  logic     done;
  pgw_rsp_t result;
  logic     cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [63:0] desc_shadow [0:NUM_TABLES*TABLE_ENTRIES-1];
  pgw_cfg_t    walk_cfg;
  pgw_rsp_t    pending_rsp [$];
  stim_row_t   stim_rows [$];
  int          err_count;
  int          idle_pct;
  int          stall_cnt;

  stage1_page_table_walker #(.NUM_TABLES(NUM_TABLES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Walk the shadow tables the same way the block does; writes update the shadow.
  function automatic pgw_rsp_t predict_walk(input pgw_req_t req);
    pgw_rsp_t    r;
    logic [63:0] e;
    logic [36:0] slot;
    logic [35:0] page;
    logic [8:0]  ent;
    logic [47:0] omask;
    logic [2:0]  ai;
    int          lvl;
    r = '0;
    if (req.op == OP_WRITE) begin
      desc_shadow[req.word_index] = req.word_data;
      return r;
    end
    if (req.virt_addr[55] != walk_cfg.context_is_kernel) return r;
    slot = {33'd0, walk_cfg.root_table};
    for (lvl = 3; lvl >= 0; lvl--) begin
      if (slot >= 37'(NUM_TABLES)) begin
        r.bad_table = 1'b1;
        return r;
      end
      ent = req.virt_addr[12 + 9*lvl +: 9];
      e = desc_shadow[{slot[3:0], ent}];
      if (!e[0]) return r;
      if (lvl == 0 || !e[1]) begin
        omask = (48'd1 << (12 + 9*lvl)) - 48'd1;
        ai = e[4:2];
        r.hit        = 1'b1;
        r.phys_addr  = (e[47:0] & ADDR_BITS & ~omask) | (req.virt_addr[47:0] & omask);
        r.can_write  = ~e[7];
        r.can_exec   = e[6] ? ~e[54] : ~e[53];
        r.is_user    = e[6];
        r.cache_mode = (ai == walk_cfg.device_attr_index) ? CACHE_DEVICE :
                       (ai == walk_cfg.noncached_attr_index) ? CACHE_NC : CACHE_WB;
        r.size_level = lvl[1:0];
        return r;
      end
      page = e[47:12];
      if (page < walk_cfg.table_base_page) begin
        r.bad_table = 1'b1;
        return r;
      end
      slot = {1'b0, page} - {1'b0, walk_cfg.table_base_page};
    end
    return r;
  endfunction

  function automatic pgw_cfg_t mk_cfg(input logic [3:0] root, input logic [35:0] base,
                                      input logic kernel, input logic [2:0] dev,
                                      input logic [2:0] nc);
    pgw_cfg_t c;
    c.root_table           = root;
    c.table_base_page      = base;
    c.context_is_kernel    = kernel;
    c.device_attr_index    = dev;
    c.noncached_attr_index = nc;
    return c;
  endfunction

  function automatic pgw_cfg_t rand_cfg(input int n);
    pgw_cfg_t    c;
    logic [63:0] r;
    logic [2:0]  dev;
    r = rand64();
    dev = 3'($urandom_range(0, 7));
    c = mk_cfg(4'($urandom_range(0, 15)), '0, 1'($urandom_range(0, 1)), dev,
               ($urandom_range(0, 4) == 0) ? dev : 3'($urandom_range(0, 7)));
    case ($urandom_range(0, 3))
      0:       c.table_base_page = 36'($urandom_range(0, 64));
      1:       c.table_base_page = r[35:0];
      2:       c.table_base_page = '0;
      default: c.table_base_page = '1;
    endcase
    if (n == 1) c = mk_cfg(4'hF, '1, 1'b1, 3'd7, 3'd7);
    if (n == 2) c = mk_cfg(4'h0, '0, 1'b0, 3'd0, 3'd7);
    return c;
  endfunction

  // Entry indices cluster on a few values so random walks find filled entries.
  function automatic logic [8:0] pick_entry();
    int p;
    p = $urandom_range(0, 9);
    if (p < 8) return 9'($urandom_range(0, 3));
    if (p == 8) return 9'h1FF;
    return 9'($urandom_range(0, 511));
  endfunction

  function automatic pgw_req_t gen_item();
    pgw_req_t    q;
    logic [63:0] d;
    logic [63:0] r;
    logic [35:0] page;
    logic [3:0]  slot;
    int          pick;
    int          kind;
    int          lvl;
    q.op         = OP_WRITE;
    q.virt_addr  = rand64();
    q.word_index = 13'($urandom_range(0, 8191));
    q.word_data  = rand64();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      slot = 4'($urandom_range(0, 15));
      d = rand64();
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        r = rand64();
        if ($urandom_range(0, 9) == 0) page = r[35:0];
        else page = walk_cfg.table_base_page + 36'($urandom_range(0, 15));
        d[47:12] = page;
        d[1:0] = 2'b11;
      end else if (kind < 85) begin
        d[1:0] = 2'b01;
      end else begin
        d[0] = 1'b0;
      end
      q.word_index = {slot, pick_entry()};
      q.word_data  = d;
    end else if (pick < 85) begin
      q.op = OP_TRANSLATE;
      for (lvl = 0; lvl < 4; lvl++) q.virt_addr[12 + 9*lvl +: 9] = pick_entry();
      q.virt_addr[55] = ($urandom_range(0, 9) == 0) ? ~walk_cfg.context_is_kernel
                                                    : walk_cfg.context_is_kernel;
    end else if (pick >= 92) begin
      q.op = OP_TRANSLATE;
    end
    return q;
  endfunction

  function automatic void add_item(input pgw_op_t op, input logic [63:0] va,
                                   input logic [12:0] idx, input logic [63:0] data,
                                   input bit has_exp, input pgw_rsp_t exp_rsp);
    stim_row_t row;
    row.kind           = ROW_ITEM;
    row.req.op         = op;
    row.req.virt_addr  = va;
    row.req.word_index = idx;
    row.req.word_data  = data;
    row.cfg            = '0;
    row.has_exp        = has_exp;
    row.exp_rsp        = exp_rsp;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input pgw_cfg_t c);
    stim_row_t row;
    row.kind    = ROW_CFG;
    row.req     = '0;
    row.cfg     = c;
    row.has_exp = 1'b0;
    row.exp_rsp = '0;
    stim_rows.push_back(row);
  endfunction

  task automatic send_item(input pgw_req_t req, input bit has_exp, input pgw_rsp_t exp_rsp);
    pgw_rsp_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_walk(req);
    pending_rsp.push_back(has_exp ? exp_rsp : predicted);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  // Unused upper data bits carry random junk; the block keeps only the field width.
  task automatic cfg_put(input pgw_reg_t r, input logic [35:0] val, input int nbits);
    logic [63:0] junk;
    logic [35:0] keep;
    junk = rand64();
    keep = (36'd1 << nbits) - 36'd1;
    if (nbits >= 36) keep = '1;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= (junk[35:0] & ~keep) | (val & keep);
  endtask

  task automatic load_cfg(input pgw_cfg_t c);
    cfg_put(REG_ROOT_TABLE, {32'd0, c.root_table}, 4);
    cfg_put(REG_TABLE_BASE_PAGE, c.table_base_page, 36);
    cfg_put(REG_CONTEXT_KERNEL, {35'd0, c.context_is_kernel}, 1);
    cfg_put(REG_DEVICE_ATTR, {33'd0, c.device_attr_index}, 3);
    cfg_put(REG_NONCACHED_ATTR, {33'd0, c.noncached_attr_index}, 3);
    @(negedge clk);
    cfg_we <= 1'b0;
    walk_cfg = c;
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    pgw_rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no transaction pending: %h", result);
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("hit", 48'(want.hit), 48'(result.hit));
        check_field("bad_table", 48'(want.bad_table), 48'(result.bad_table));
        check_field("phys_addr", want.phys_addr, result.phys_addr);
        check_field("can_write", 48'(want.can_write), 48'(result.can_write));
        check_field("can_exec", 48'(want.can_exec), 48'(result.can_exec));
        check_field("is_user", 48'(want.is_user), 48'(result.is_user));
        check_field("cache_mode", 48'(want.cache_mode), 48'(result.cache_mode));
        check_field("size_level", 48'(want.size_level), 48'(result.size_level));
      end
    end
  end

  // Watchdog: cycles with neither an accepted transaction nor a result
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb_stage1_page_table_walker NOT OK");
        $finish;
      end
    end
  end

  initial begin
    pgw_rsp_t rsp_none;
    pgw_rsp_t rsp_bad;
    int       i;
    int       pass;
    int       set_no;
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    err_count = 0;
    stall_cnt = 0;
    idle_pct  = 13;
    set_no    = 0;
    walk_cfg  = mk_cfg(4'h0, '0, 1'b0, 3'd0, 3'd1);
    for (i = 0; i < NUM_TABLES*TABLE_ENTRIES; i++) desc_shadow[i] = '0;
    rsp_none = '0;
    rsp_bad  = '0;
    rsp_bad.bad_table = 1'b1;

    // Reset register values until the first config row.
    add_item(OP_TRANSLATE, 64'h0, 13'h0, 64'h0, 1'b1, rsp_none);
    add_item(OP_TRANSLATE, 64'h0080_0000_0000_0000, 13'h0, 64'h0, 1'b1, rsp_none);
    add_item(OP_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 13'h0, 64'h0, 1'b1, rsp_none);
    add_item(OP_WRITE, 64'h0, 13'd0, 64'h0000_0000_0000_0041, 1'b1, rsp_none);
    add_item(OP_TRANSLATE, 64'h0000_0012_3456_789A, 13'h0, 64'h0, 1'b0, rsp_none);
    // Four-level chain: slot 0 -> 1 -> 2 -> 3
    add_item(OP_WRITE, 64'h0, 13'd1, 64'h0000_0000_0000_1003, 1'b1, rsp_none);
    add_item(OP_WRITE, 64'h0, 13'd514, 64'h0000_0000_0000_2003, 1'b1, rsp_none);
    add_item(OP_WRITE, 64'h0, 13'd1027, 64'h0000_0000_0000_3003, 1'b1, rsp_none);
    add_item(OP_WRITE, 64'h0, 13'd1540, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, rsp_none);
    add_item(OP_TRANSLATE, WALK_VA, 13'h0, 64'h0, 1'b0, rsp_none);
    add_item(OP_TRANSLATE, WALK_VA | 64'hFF7F_0000_0000_0000, 13'h1FFF,
             64'hFFFF_FFFF_FFFF_FFFF, 1'b0, rsp_none);
    // 1 GiB block, non-cacheable attr
    add_item(OP_WRITE, 64'h0, 13'd517, 64'h0060_1234_5678_0785, 1'b1, rsp_none);
    add_item(OP_TRANSLATE, 64'h0000_0081_6ABC_DEF0, 13'h0, 64'h0, 1'b0, rsp_none);
    // 2 MiB block with PXN set
    add_item(OP_WRITE, 64'h0, 13'd1030, 64'h0020_0000_ABC0_0C49, 1'b1, rsp_none);
    add_item(OP_TRANSLATE, 64'h0000_0080_80DF_FFFF, 13'h0, 64'h0, 1'b0, rsp_none);
    // next table far outside the store
    add_item(OP_WRITE, 64'h0, 13'd7, 64'h000F_FFFF_FFFF_F003, 1'b1, rsp_none);
    add_item(OP_TRANSLATE, 64'h0000_0380_0000_0000, 13'h0, 64'h0, 1'b1, rsp_bad);
    // invalid entry at the second level
    add_item(OP_TRANSLATE, 64'h0000_0082_4000_0000, 13'h0, 64'h0, 1'b1, rsp_none);
    // both attr indices equal; next table page below the base
    add_cfg(mk_cfg(4'h0, 36'd8, 1'b0, 3'd3, 3'd3));
    add_item(OP_TRANSLATE, WALK_VA, 13'h0, 64'h0, 1'b1, rsp_bad);
    add_item(OP_WRITE, 64'h0, 13'd2, 64'h0000_0000_0000_000D, 1'b1, rsp_none);
    add_item(OP_TRANSLATE, 64'h0000_017F_FFFF_FFFF, 13'h0, 64'h0, 1'b0, rsp_none);
    // kernel half, top slot, maximum base
    add_cfg(mk_cfg(4'hF, '1, 1'b1, 3'd7, 3'd0));
    add_item(OP_WRITE, 64'h0, 13'd8191, 64'hFFFF_FFFF_FFFF_FFFD, 1'b1, rsp_none);
    add_item(OP_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 13'h0, 64'h0, 1'b0, rsp_none);
    add_item(OP_TRANSLATE, 64'h0000_FFFF_FFFF_FFFF, 13'h0, 64'h0, 1'b1, rsp_none);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        wait_idle();
        load_cfg(stim_rows[i].cfg);
      end else begin
        send_item(stim_rows[i].req, stim_rows[i].has_exp, stim_rows[i].exp_rsp);
      end
    end

    for (pass = 0; pass < 3; pass++) begin
      idle_pct = (pass == 0) ? 13 : (pass == 1) ? 66 : 0;
      repeat (SETS_PER_PASS) begin
        wait_idle();
        load_cfg(rand_cfg(set_no));
        set_no++;
        repeat (ITEMS_PER_SET) send_item(gen_item(), 1'b0, rsp_none);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("tb_stage1_page_table_walker OK");
    end else begin
      $display("tb_stage1_page_table_walker NOT OK");
    end
    $finish;
  end

endmodule

// ===== stage1_page_table_walker.f =====
hw/rtl/pgw_pkg.sv
hw/rtl/pgw_table_mem.sv
hw/rtl/pgw_walker.sv
hw/rtl/stage1_page_table_walker.sv
tb/tb_stage1_page_table_walker.sv
